[hw/rtl/brs_pkg.sv]
// Shared types, codes and reset values of the blind relay sequencer.
package brs_pkg;

   localparam int TIME_W = 32;
   localparam int RUN_W = 20;
   localparam int DWELL_W = 16;
   localparam int MODE_W = 3;
   localparam int CMD_W = 3;
   localparam int MOTION_W = 2;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 20;

   localparam logic [MOTION_W-1:0] MOT_STOP = 2'd0;
   localparam logic [MOTION_W-1:0] MOT_PREPARE = 2'd1;
   localparam logic [MOTION_W-1:0] MOT_UP = 2'd2;
   localparam logic [MOTION_W-1:0] MOT_DOWN = 2'd3;

   localparam logic [CMD_W-1:0] CMD_UP = 3'd0;
   localparam logic [CMD_W-1:0] CMD_STOP = 3'd1;
   localparam logic [CMD_W-1:0] CMD_DOWN = 3'd2;
   localparam logic [CMD_W-1:0] CMD_DOWN_OR_STOP = 3'd3;
   localparam logic [CMD_W-1:0] CMD_UP_OR_STOP = 3'd4;

   localparam logic [MODE_W-1:0] MODE_POWER_UP = 3'd0;
   localparam logic [MODE_W-1:0] MODE_POWER_DOWN = 3'd1;
   localparam logic [MODE_W-1:0] MODE_UP_POWER = 3'd2;
   localparam logic [MODE_W-1:0] MODE_DOWN_POWER = 3'd3;
   localparam logic [MODE_W-1:0] MODE_UP_DOWN = 3'd4;
   localparam logic [MODE_W-1:0] MODE_DOWN_UP = 3'd5;

   localparam logic REQ_TICK = 1'b0;
   localparam logic REQ_COMMAND = 1'b1;

   localparam logic STATUS_OK = 1'b0;
   localparam logic STATUS_BAD_CMD = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_INTERLOCK_MODE = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_UP_RUN_MS = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DOWN_RUN_MS = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_STOP_DWELL_MS = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_PREPARE_DWELL_MS = 3'd4;

   localparam logic [MODE_W-1:0] RST_INTERLOCK_MODE = 3'd0;
   localparam logic [RUN_W-1:0] RST_UP_RUN_MS = 20'd60000;
   localparam logic [RUN_W-1:0] RST_DOWN_RUN_MS = 20'd60000;
   localparam logic [DWELL_W-1:0] RST_STOP_DWELL_MS = 16'd500;
   localparam logic [DWELL_W-1:0] RST_PREPARE_DWELL_MS = 16'd200;

   typedef struct packed {
      logic [MODE_W-1:0] interlock_mode;
      logic [RUN_W-1:0] up_run_ms;
      logic [RUN_W-1:0] down_run_ms;
      logic [DWELL_W-1:0] stop_dwell_ms;
      logic [DWELL_W-1:0] prepare_dwell_ms;
   } brs_cfg_type;

   typedef struct packed {
      logic relay1_on;
      logic relay2_on;
      logic [MOTION_W-1:0] motion_state;
      logic [MOTION_W-1:0] target_state;
      logic status;
   } brs_result_type;

endpackage

[hw/rtl/brs_if.sv]
// Valid/ready channel interfaces for requests and responses.
interface brs_req_if;
   import brs_pkg::*;
   logic valid;
   logic ready;
   logic req_type;
   logic [CMD_W-1:0] command;
   logic [TIME_W-1:0] now_ms;
   modport source (output valid, req_type, command, now_ms, input ready);
   modport sink (input valid, req_type, command, now_ms, output ready);
endinterface

interface brs_rsp_if;
   import brs_pkg::*;
   logic valid;
   logic ready;
   logic relay1_on;
   logic relay2_on;
   logic [MOTION_W-1:0] motion_state;
   logic [MOTION_W-1:0] target_state;
   logic status;
   modport source (output valid, relay1_on, relay2_on, motion_state, target_state, status,
                   input ready);
   modport sink (input valid, relay1_on, relay2_on, motion_state, target_state, status,
                 output ready);
endinterface

[hw/rtl/brs_csr.sv]
// Configuration registers of the blind relay sequencer.
module brs_csr
   import brs_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output brs_cfg_type cfg
);

   brs_cfg_type cfg_ff;
   brs_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_INTERLOCK_MODE: cfg_in.interlock_mode = csr_wdata[MODE_W-1:0];
            CSR_UP_RUN_MS: cfg_in.up_run_ms = csr_wdata[RUN_W-1:0];
            CSR_DOWN_RUN_MS: cfg_in.down_run_ms = csr_wdata[RUN_W-1:0];
            CSR_STOP_DWELL_MS: cfg_in.stop_dwell_ms = csr_wdata[DWELL_W-1:0];
            CSR_PREPARE_DWELL_MS: cfg_in.prepare_dwell_ms = csr_wdata[DWELL_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.interlock_mode <= RST_INTERLOCK_MODE;
         cfg_ff.up_run_ms <= RST_UP_RUN_MS;
         cfg_ff.down_run_ms <= RST_DOWN_RUN_MS;
         cfg_ff.stop_dwell_ms <= RST_STOP_DWELL_MS;
         cfg_ff.prepare_dwell_ms <= RST_PREPARE_DWELL_MS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[hw/rtl/brs_engine.sv]
// Motion state, relay levels and the per-item sequencing logic.
module brs_engine
   import brs_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  brs_cfg_type cfg,
   input  logic step,
   input  logic req_type,
   input  logic [CMD_W-1:0] command,
   input  logic [TIME_W-1:0] now_ms,
   output brs_result_type result
);

   localparam logic [2:0] ACT_NONE = 3'd0;
   localparam logic [2:0] ACT_STOP = 3'd1;
   localparam logic [2:0] ACT_PREP_UP = 3'd2;
   localparam logic [2:0] ACT_PREP_DOWN = 3'd3;
   localparam logic [2:0] ACT_UP = 3'd4;
   localparam logic [2:0] ACT_DOWN = 3'd5;

   logic [MOTION_W-1:0] cm_ff, cm_in;
   logic [MOTION_W-1:0] rm_ff, rm_in;
   logic [TIME_W-1:0] lct_ff, lct_in;
   logic relay1_ff, relay1_in;
   logic relay2_ff, relay2_in;

   logic [TIME_W-1:0] elapsed;
   logic [TIME_W-1:0] dwell_elapsed;
   logic expire;
   logic stop_taken;
   logic [MOTION_W-1:0] rm_tick;
   logic [MOTION_W-1:0] cm_after;
   logic [2:0] action;
   logic status;

   // Next-state logic of one item; a tick takes at most one motion transition.
   always_comb begin
      elapsed = now_ms - lct_ff;
      expire = ((cm_ff == MOT_UP) && (elapsed >= {{(TIME_W-RUN_W){1'b0}}, cfg.up_run_ms})) ||
               ((cm_ff == MOT_DOWN) &&
                (elapsed >= {{(TIME_W-RUN_W){1'b0}}, cfg.down_run_ms}));
      rm_tick = expire ? MOT_STOP : rm_ff;
      stop_taken = (cm_ff != rm_tick) && (rm_tick == MOT_STOP);
      cm_after = stop_taken ? MOT_STOP : cm_ff;
      dwell_elapsed = stop_taken ? '0 : elapsed;
      action = ACT_NONE;
      if (cm_ff != rm_tick) begin
         if ((cm_after == MOT_STOP) &&
             (dwell_elapsed >= {{(TIME_W-DWELL_W){1'b0}}, cfg.stop_dwell_ms})) begin
            if (rm_tick == MOT_DOWN) begin
               action = ACT_PREP_DOWN;
            end else if (rm_tick == MOT_UP) begin
               action = ACT_PREP_UP;
            end else begin
               action = ACT_STOP;
            end
         end else if ((cm_after == MOT_PREPARE) &&
                      (dwell_elapsed >= {{(TIME_W-DWELL_W){1'b0}},
                                         cfg.prepare_dwell_ms})) begin
            if (rm_tick == MOT_DOWN) begin
               action = ACT_DOWN;
            end else if (rm_tick == MOT_UP) begin
               action = ACT_UP;
            end else begin
               action = ACT_STOP;
            end
         end else if (stop_taken) begin
            action = ACT_STOP;
         end
      end

      cm_in = cm_ff;
      rm_in = rm_ff;
      lct_in = lct_ff;
      relay1_in = relay1_ff;
      relay2_in = relay2_ff;
      status = STATUS_OK;

      if (req_type == REQ_COMMAND) begin
         case (command)
            CMD_UP: rm_in = MOT_UP;
            CMD_STOP: rm_in = MOT_STOP;
            CMD_DOWN: rm_in = MOT_DOWN;
            CMD_DOWN_OR_STOP: rm_in = (cm_ff == MOT_STOP) ? MOT_DOWN : MOT_STOP;
            CMD_UP_OR_STOP: rm_in = (cm_ff == MOT_STOP) ? MOT_UP : MOT_STOP;
            default: status = STATUS_BAD_CMD;
         endcase
      end else begin
         rm_in = rm_tick;
         if (action != ACT_NONE) begin
            lct_in = now_ms;
         end
         case (action)
            ACT_STOP: begin
               cm_in = MOT_STOP;
               case (cfg.interlock_mode)
                  MODE_POWER_UP, MODE_POWER_DOWN: relay1_in = 1'b0;
                  MODE_UP_POWER, MODE_DOWN_POWER: relay2_in = 1'b0;
                  MODE_UP_DOWN, MODE_DOWN_UP: begin
                     relay1_in = 1'b0;
                     relay2_in = 1'b0;
                  end
                  default: relay1_in = relay1_ff;
               endcase
            end
            ACT_PREP_UP, ACT_PREP_DOWN: begin
               cm_in = MOT_PREPARE;
               case (cfg.interlock_mode)
                  MODE_POWER_UP: relay2_in = (action == ACT_PREP_UP);
                  MODE_POWER_DOWN: relay2_in = (action == ACT_PREP_DOWN);
                  MODE_UP_POWER: relay1_in = (action == ACT_PREP_UP);
                  MODE_DOWN_POWER: relay1_in = (action == ACT_PREP_DOWN);
                  default: relay1_in = relay1_ff;
               endcase
            end
            ACT_UP: begin
               cm_in = MOT_UP;
               case (cfg.interlock_mode)
                  MODE_POWER_UP, MODE_POWER_DOWN, MODE_UP_DOWN: relay1_in = 1'b1;
                  MODE_UP_POWER, MODE_DOWN_POWER, MODE_DOWN_UP: relay2_in = 1'b1;
                  default: relay1_in = relay1_ff;
               endcase
            end
            ACT_DOWN: begin
               cm_in = MOT_DOWN;
               case (cfg.interlock_mode)
                  MODE_POWER_UP, MODE_POWER_DOWN, MODE_DOWN_UP: relay1_in = 1'b1;
                  MODE_UP_POWER, MODE_DOWN_POWER, MODE_UP_DOWN: relay2_in = 1'b1;
                  default: relay1_in = relay1_ff;
               endcase
            end
            default: cm_in = cm_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cm_ff <= MOT_STOP;
         rm_ff <= MOT_STOP;
         lct_ff <= '0;
         relay1_ff <= 1'b0;
         relay2_ff <= 1'b0;
      end else if (step) begin
         cm_ff <= cm_in;
         rm_ff <= rm_in;
         lct_ff <= lct_in;
         relay1_ff <= relay1_in;
         relay2_ff <= relay2_in;
      end
   end

   assign result.relay1_on = relay1_in;
   assign result.relay2_on = relay2_in;
   assign result.motion_state = cm_in;
   assign result.target_state = rm_in;
   assign result.status = status;

`ifndef SYNTHESIS
   a_target_never_prepare: assert property (@(posedge clock) disable iff (reset)
      rm_ff != MOT_PREPARE)
      else $error("requested motion holds the prepare code");

   a_command_keeps_motion: assert property (@(posedge clock) disable iff (reset)
      step && (req_type == REQ_COMMAND) |=> $stable(cm_ff) && $stable(lct_ff))
      else $error("command transfer changed motion or timestamp");

   a_transition_stamps_time: assert property (@(posedge clock) disable iff (reset)
      step && (cm_in != cm_ff) |=> lct_ff == $past(now_ms))
      else $error("motion transition did not record the tick time");
`endif

endmodule

[hw/rtl/blind_relay_sequencer.sv]
// Top level of the blind relay sequencer: input register, engine and result register.
// A transfer is held in the input register; the engine result is registered for rsp.
// Throughput: one item per cycle while rsp is ready, else the engine stalls.
// Reset (synchronous, active high) sets motion and target to stop, both relays off,
// the change time to zero, configuration to its defaults and empties both registers.
module blind_relay_sequencer
   import brs_pkg::*;
(
   input  logic clock,
   input  logic reset,
   brs_req_if.sink req,
   brs_rsp_if.source rsp,
   input  logic csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   brs_cfg_type cfg;
   brs_result_type result;

   logic s1_valid_ff;
   logic s1_type_ff;
   logic [CMD_W-1:0] s1_cmd_ff;
   logic [TIME_W-1:0] s1_now_ff;
   logic out_valid_ff;
   brs_result_type out_result_ff;
   logic advance;
   logic req_take;

   assign advance = s1_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !s1_valid_ff || advance;
   assign req_take = req.valid && req.ready;

   brs_csr u_csr (
      .clock(clock),
      .reset(reset),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .cfg(cfg)
   );

   brs_engine u_engine (
      .clock(clock),
      .reset(reset),
      .cfg(cfg),
      .step(advance),
      .req_type(s1_type_ff),
      .command(s1_cmd_ff),
      .now_ms(s1_now_ff),
      .result(result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_take) begin
            s1_valid_ff <= 1'b1;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_type_ff <= req.req_type;
         s1_cmd_ff <= req.command;
         s1_now_ff <= req.now_ms;
      end
      if (advance) begin
         out_result_ff <= result;
      end
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.relay1_on = out_result_ff.relay1_on;
   assign rsp.relay2_on = out_result_ff.relay2_on;
   assign rsp.motion_state = out_result_ff.motion_state;
   assign rsp.target_state = out_result_ff.target_state;
   assign rsp.status = out_result_ff.status;

`ifndef SYNTHESIS
   a_pending_reaches_output: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_valid_ff |=> out_valid_ff)
      else $error("held item did not move to the result register");

   a_accept_fills_input: assert property (@(posedge clock) disable iff (reset)
      req_take |=> s1_valid_ff)
      else $error("accepted transfer was not captured");

   a_empty_is_ready: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req.ready)
      else $error("empty input register refused a transfer");
`endif

endmodule

[verif/blind_relay_checker.sv]
// Checker that predicts every result of the blind relay sequencer and compares it on rsp.
module blind_relay_checker
   import brs_pkg::*;
(
   input  logic clock,
   input  logic reset,
   brs_req_if req,
   brs_rsp_if rsp,
   input  logic csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int fail_count,
   output int pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   brs_cfg_type cfg;
   logic [MOTION_W-1:0] motion_now;
   logic [MOTION_W-1:0] motion_goal;
   logic [TIME_W-1:0] changed_at;
   logic relay1;
   logic relay2;
   brs_result_type expected_outputs[$];
   int errors = 0;

   initial begin
      fail_count = 0;
      pending_count = 0;
   end

   task automatic move_to(input logic [MOTION_W-1:0] target, input logic [TIME_W-1:0] now);
      logic up_dir;
      up_dir = (motion_goal == MOT_UP);
      motion_now = target;
      changed_at = now;
      case (target)
         MOT_PREPARE: begin
            case (cfg.interlock_mode)
               MODE_POWER_UP: relay2 = up_dir;
               MODE_POWER_DOWN: relay2 = !up_dir;
               MODE_UP_POWER: relay1 = up_dir;
               MODE_DOWN_POWER: relay1 = !up_dir;
               default: ;
            endcase
         end
         MOT_UP: begin
            case (cfg.interlock_mode)
               MODE_POWER_UP, MODE_POWER_DOWN, MODE_UP_DOWN: relay1 = 1'b1;
               MODE_UP_POWER, MODE_DOWN_POWER, MODE_DOWN_UP: relay2 = 1'b1;
               default: ;
            endcase
         end
         MOT_DOWN: begin
            case (cfg.interlock_mode)
               MODE_POWER_UP, MODE_POWER_DOWN, MODE_DOWN_UP: relay1 = 1'b1;
               MODE_UP_POWER, MODE_DOWN_POWER, MODE_UP_DOWN: relay2 = 1'b1;
               default: ;
            endcase
         end
         default: begin
            case (cfg.interlock_mode)
               MODE_POWER_UP, MODE_POWER_DOWN: relay1 = 1'b0;
               MODE_UP_POWER, MODE_DOWN_POWER: relay2 = 1'b0;
               MODE_UP_DOWN, MODE_DOWN_UP: begin
                  relay1 = 1'b0;
                  relay2 = 1'b0;
               end
               default: ;
            endcase
         end
      endcase
   endtask

   task automatic advance_blind(input logic kind, input logic [CMD_W-1:0] cmd,
                                input logic [TIME_W-1:0] now, output brs_result_type res);
      logic [TIME_W-1:0] elapsed;
      logic status;
      status = STATUS_OK;
      if (kind == REQ_COMMAND) begin
         case (cmd)
            CMD_UP: motion_goal = MOT_UP;
            CMD_STOP: motion_goal = MOT_STOP;
            CMD_DOWN: motion_goal = MOT_DOWN;
            CMD_DOWN_OR_STOP: motion_goal = (motion_now == MOT_STOP) ? MOT_DOWN : MOT_STOP;
            CMD_UP_OR_STOP: motion_goal = (motion_now == MOT_STOP) ? MOT_UP : MOT_STOP;
            default: status = STATUS_BAD_CMD;
         endcase
      end else begin
         elapsed = now - changed_at;
         if ((motion_now == MOT_UP && elapsed >= TIME_W'(cfg.up_run_ms)) ||
             (motion_now == MOT_DOWN && elapsed >= TIME_W'(cfg.down_run_ms))) begin
            motion_goal = MOT_STOP;
         end
         if (motion_now != motion_goal) begin
            if (motion_goal == MOT_STOP) begin
               move_to(MOT_STOP, now);
            end
            elapsed = now - changed_at;
            if (motion_now == MOT_STOP && elapsed >= TIME_W'(cfg.stop_dwell_ms)) begin
               move_to((motion_goal == MOT_STOP) ? MOT_STOP : MOT_PREPARE, now);
            end else if (motion_now == MOT_PREPARE &&
                         elapsed >= TIME_W'(cfg.prepare_dwell_ms)) begin
               move_to(motion_goal, now);
            end
         end
      end
      res = {relay1, relay2, motion_now, motion_goal, status};
   endtask

   task automatic check_field(input string name, input logic [MOTION_W-1:0] want_v,
                              input logic [MOTION_W-1:0] got_v);
      if (want_v !== got_v) begin
         $error("%s mismatch: expected %0d, got %0d", name, want_v, got_v);
         errors++;
      end
   endtask

   always @(posedge clock) begin : monitor
      brs_result_type want;
      brs_result_type got;
      if (reset) begin
         cfg.interlock_mode = RST_INTERLOCK_MODE;
         cfg.up_run_ms = RST_UP_RUN_MS;
         cfg.down_run_ms = RST_DOWN_RUN_MS;
         cfg.stop_dwell_ms = RST_STOP_DWELL_MS;
         cfg.prepare_dwell_ms = RST_PREPARE_DWELL_MS;
         motion_now = MOT_STOP;
         motion_goal = MOT_STOP;
         changed_at = '0;
         relay1 = 1'b0;
         relay2 = 1'b0;
         expected_outputs.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_INTERLOCK_MODE: cfg.interlock_mode = csr_wdata[MODE_W-1:0];
               CSR_UP_RUN_MS: cfg.up_run_ms = csr_wdata[RUN_W-1:0];
               CSR_DOWN_RUN_MS: cfg.down_run_ms = csr_wdata[RUN_W-1:0];
               CSR_STOP_DWELL_MS: cfg.stop_dwell_ms = csr_wdata[DWELL_W-1:0];
               CSR_PREPARE_DWELL_MS: cfg.prepare_dwell_ms = csr_wdata[DWELL_W-1:0];
               default: ;
            endcase
         end
         if (rsp.valid && rsp.ready) begin
            got = {rsp.relay1_on, rsp.relay2_on, rsp.motion_state, rsp.target_state,
                   rsp.status};
            if (expected_outputs.size() == 0) begin
               $error("Result transfer arrived with no outstanding request.");
               errors++;
            end else begin
               want = expected_outputs.pop_front();
               check_field("relay1_on", want.relay1_on, got.relay1_on);
               check_field("relay2_on", want.relay2_on, got.relay2_on);
               check_field("motion_state", want.motion_state, got.motion_state);
               check_field("target_state", want.target_state, got.target_state);
               check_field("status", want.status, got.status);
            end
         end
         if (req.valid && req.ready) begin
            advance_blind(req.req_type, req.command, req.now_ms, want);
            expected_outputs = {expected_outputs, want};
         end
      end
      pending_count <= expected_outputs.size();
      fail_count <= errors;
   end

endmodule

[verif/blind_relay_sequencer_tb.sv]
// Testbench top of the blind relay sequencer: clock, reset, stimulus and verdict.
module blind_relay_sequencer_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import brs_pkg::*;

   logic clock;
   logic reset;
   logic csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int fail_count;
   int pending_count;
   int burst_left = 0;

   brs_req_if req_ch();
   brs_rsp_if rsp_ch();

   blind_relay_sequencer i_dut (
      .clock(clock),
      .reset(reset),
      .req(req_ch),
      .rsp(rsp_ch),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   blind_relay_checker i_checker (
      .clock(clock),
      .reset(reset),
      .req(req_ch),
      .rsp(rsp_ch),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .fail_count(fail_count),
      .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      int rx_cycle;
      int rx_style;
      rsp_ch.ready = 1'b0;
      rx_cycle = 0;
      rx_style = 0;
      forever begin
         @(posedge clock);
         if (rx_cycle % 48 == 0) begin
            rx_style = $urandom_range(0, 3);
         end
         case (rx_style)
            0: rsp_ch.ready <= 1'b1;
            1: rsp_ch.ready <= 1'($urandom_range(0, 1));
            2: rsp_ch.ready <= (rx_cycle % 5 == 0);
            default: rsp_ch.ready <= ($urandom_range(0, 7) != 0);
         endcase
         rx_cycle++;
      end
   end

   task automatic send_item(input logic kind, input logic [CMD_W-1:0] cmd,
                            input logic [TIME_W-1:0] stamp);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_ch.valid <= 1'b1;
      req_ch.req_type <= kind;
      req_ch.command <= cmd;
      req_ch.now_ms <= stamp;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic wait_for_results();
      req_ch.valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (pending_count != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic apply_settings(input logic [MODE_W-1:0] mode,
                                 input logic [RUN_W-1:0] up_ms, input logic [RUN_W-1:0] dn_ms,
                                 input logic [DWELL_W-1:0] stop_ms,
                                 input logic [DWELL_W-1:0] prep_ms);
      write_reg(CSR_INTERLOCK_MODE, CSR_DATA_W'({$urandom(), mode}));
      write_reg(CSR_UP_RUN_MS, up_ms);
      write_reg(CSR_DOWN_RUN_MS, dn_ms);
      write_reg(CSR_STOP_DWELL_MS, CSR_DATA_W'({$urandom(), stop_ms}));
      write_reg(CSR_PREPARE_DWELL_MS, CSR_DATA_W'({$urandom(), prep_ms}));
      write_reg(CSR_PREPARE_DWELL_MS + CSR_INDEX_W'($urandom_range(1, 3)),
                CSR_DATA_W'($urandom()));
      csr_write_en <= 1'b0;
   endtask

   initial begin
      logic [MODE_W-1:0] ph_mode;
      logic [RUN_W-1:0] ph_up;
      logic [RUN_W-1:0] ph_down;
      logic [DWELL_W-1:0] ph_stop;
      logic [DWELL_W-1:0] ph_prep;
      logic [CMD_W-1:0] cmd;
      logic [TIME_W-1:0] wall_ms;
      logic [TIME_W-1:0] step_ms;
      int span;
      int roll;

      reset = 1'b1;
      csr_write_en = 1'b0;
      csr_index = CSR_INTERLOCK_MODE;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.req_type = REQ_TICK;
      req_ch.command = CMD_UP;
      req_ch.now_ms = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Full up run at the reset settings, then a direct reversal that is dropped
      // when the run time expires and sets the target to stop.
      send_item(REQ_COMMAND, CMD_UP, $urandom());
      send_item(REQ_TICK, CMD_W'($urandom()), 32'd100);
      send_item(REQ_TICK, CMD_W'($urandom()), 32'd500);
      send_item(REQ_TICK, CMD_W'($urandom()), 32'd700);
      send_item(REQ_COMMAND, CMD_DOWN, $urandom());
      send_item(REQ_TICK, CMD_W'($urandom()), 32'd1000);
      send_item(REQ_TICK, CMD_W'($urandom()), 32'd60700);
      send_item(REQ_COMMAND, CMD_DOWN_OR_STOP, $urandom());
      send_item(REQ_TICK, CMD_W'($urandom()), 32'd61200);
      send_item(REQ_TICK, CMD_W'($urandom()), 32'd61400);
      send_item(REQ_COMMAND, CMD_UP_OR_STOP, $urandom());
      send_item(REQ_TICK, CMD_W'($urandom()), 32'd61401);
      send_item(REQ_COMMAND, CMD_UP_OR_STOP, $urandom());
      send_item(REQ_COMMAND, CMD_STOP, $urandom());
      for (int c = CMD_UP_OR_STOP + 1; c < (1 << CMD_W); c++) begin
         send_item(REQ_COMMAND, CMD_W'(c), $urandom());
      end
      // Down sequence across the wrap of the millisecond counter.
      send_item(REQ_TICK, CMD_W'($urandom()), 32'hFFFF_FFFF);
      send_item(REQ_COMMAND, CMD_DOWN, $urandom());
      send_item(REQ_TICK, CMD_W'($urandom()), 32'hFFFF_FFFE);
      send_item(REQ_TICK, CMD_W'($urandom()), 32'h0000_00C6);
      send_item(REQ_COMMAND, CMD_DOWN_OR_STOP, $urandom());
      send_item(REQ_TICK, CMD_W'($urandom()), 32'h0000_00C7);
      wait_for_results();

      wall_ms = 32'hFFFF_F000;
      for (int p = 0; p < 12; p++) begin
         ph_mode = MODE_W'(p % 8);
         case (p % 4)
            1: begin
               ph_up = '0;
               ph_down = '0;
               ph_stop = '0;
               ph_prep = '0;
            end
            3: begin
               if (p == 3) begin
                  ph_up = '1;
                  ph_down = '1;
                  ph_stop = '1;
                  ph_prep = '1;
               end else begin
                  ph_up = '0;
                  ph_down = '1;
                  ph_stop = '0;
                  ph_prep = '1;
               end
            end
            default: begin
               ph_up = RUN_W'($urandom_range(0, 400));
               ph_down = RUN_W'($urandom_range(0, 400));
               ph_stop = DWELL_W'($urandom_range(0, 150));
               ph_prep = DWELL_W'($urandom_range(0, 150));
            end
         endcase
         apply_settings(ph_mode, ph_up, ph_down, ph_stop, ph_prep);
         span = int'(ph_up);
         if (int'(ph_down) > span) span = int'(ph_down);
         if (int'(ph_stop) > span) span = int'(ph_stop);
         if (int'(ph_prep) > span) span = int'(ph_prep);
         span = span + 1;

         for (int i = 0; i < 140; i++) begin
            if (i == 70 && p % 3 == 0) begin
               wait_for_results();
            end
            roll = $urandom_range(0, 99);
            if (roll < 22) begin
               case ($urandom_range(0, 8))
                  0, 1, 2: cmd = CMD_UP;
                  3, 4, 5: cmd = CMD_DOWN;
                  6: cmd = CMD_STOP;
                  7: cmd = CMD_DOWN_OR_STOP;
                  default: cmd = CMD_UP_OR_STOP;
               endcase
               send_item(REQ_COMMAND, cmd, $urandom());
            end else if (roll < 27) begin
               send_item(REQ_COMMAND, CMD_W'($urandom_range(CMD_UP_OR_STOP + 1,
                         (1 << CMD_W) - 1)), $urandom());
            end else if (roll < 30) begin
               wall_ms = $urandom();
               send_item(REQ_TICK, CMD_W'($urandom()), wall_ms);
            end else begin
               case ($urandom_range(0, 9))
                  0: step_ms = '0;
                  1: step_ms = TIME_W'(ph_stop);
                  2: step_ms = TIME_W'(ph_prep);
                  3: step_ms = TIME_W'(ph_up);
                  4: step_ms = TIME_W'(ph_down);
                  5: step_ms = TIME_W'(ph_stop) - TIME_W'(ph_stop != 0);
                  6: step_ms = TIME_W'(ph_prep) - TIME_W'(ph_prep != 0);
                  default: step_ms = $urandom_range(0, span);
               endcase
               wall_ms = wall_ms + step_ms;
               send_item(REQ_TICK, CMD_W'($urandom()), wall_ms);
            end
         end
         wait_for_results();
      end

      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/brs_pkg.sv
hw/rtl/brs_if.sv
hw/rtl/brs_csr.sv
hw/rtl/brs_engine.sv
hw/rtl/blind_relay_sequencer.sv
verif/blind_relay_checker.sv
verif/blind_relay_sequencer_tb.sv
